>>> hw/rtl/depth_shade_rgb565_core_macros.svh
// Assertion macros for the depth shade core, clocked on aclk and idle while aresetn is low.
`ifndef DEPTH_SHADE_RGB565_CORE_MACROS_SVH
`define DEPTH_SHADE_RGB565_CORE_MACROS_SVH

// same-cycle implication
`define DSR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DSR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/dsr_pkg.sv
// Shared types and constants for the depth shade RGB565 core.
package dsr_pkg;

    localparam int unsigned DEPTH_W    = 8;
    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned NUM_W      = 16;
    localparam int unsigned DIV_ITERS  = 16;
    localparam int unsigned CNT_W      = 4;
    localparam logic [7:0]  DEPTH_BACKGROUND = 8'd255;
    localparam logic [7:0]  FULL_SCALE       = 8'd255;
    localparam logic [7:0]  RED_MASK         = 8'hF8;
    localparam logic [7:0]  GREEN_MASK       = 8'hFC;

    localparam logic MODE_SCAN  = 1'b0;
    localparam logic MODE_SHADE = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
        logic [DEPTH_W-1:0] pixel_depth;
        logic              last_pixel;
    } in_beat_t;

    typedef struct packed {
        logic [15:0] pixel_word;
        logic        end_of_frame;
    } out_beat_t;

    // controller -> datapath
    typedef struct packed {
        logic scan_update;
        logic load_op;
        logic div_step;
        logic mul_load;
        logic out_load;
    } dsr_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic shade_beat;
    } dsr_status_t;

endpackage

>>> hw/rtl/dsr_ctrl.sv
// Controller state machine: sequences tracker update, divide, scale and output load.
module dsr_ctrl
    import dsr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    input  dsr_status_t status,
    output dsr_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_PACK = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (status.shade_beat) begin
                        cmd.load_op = 1'b1;
                        cnt_next    = '0;
                        state_next  = ST_DIV;
                    end else begin
                        cmd.scan_update = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_ITERS - 1)) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul_load = 1'b1;
                state_next   = ST_PACK;
            end
            ST_PACK: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

>>> hw/rtl/dsr_datapath.sv
// Datapath: depth trackers, serial shade divider, channel scaling and RGB565 packing.
module dsr_datapath
    import dsr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  in_beat_t    s_payload,
    input  dsr_cmd_t    cmd,
    output dsr_status_t status,
    output out_beat_t   m_payload
);

    // trackers
    logic [DEPTH_W-1:0] depth_low_reg, depth_high_reg;
    logic               seen_reg;

    // operand and divider registers
    logic [NUM_W-1:0]   num_reg;
    logic [DEPTH_W-1:0] den_reg;
    logic [DEPTH_W-1:0] rem_reg;
    logic               force_zero_reg, force_full_reg;
    logic [CHAN_W-1:0]  red_reg, green_reg, blue_reg;
    logic               last_reg;
    logic [NUM_W-1:0]   prod_r_reg, prod_g_reg, prod_b_reg;
    out_beat_t          out_reg;

    logic [DEPTH_W-1:0] lo_eff, hi_eff;
    logic               full_range;
    logic [DEPTH_W-1:0] span_hi;
    logic [DEPTH_W:0]   rem_shift;
    logic               q_bit;
    logic [DEPTH_W-1:0] shade;
    logic [CHAN_W-1:0]  red_s, green_s, blue_s;
    logic [15:0]        word;

    // exact x / 255 for x up to 255*255
    function automatic logic [CHAN_W-1:0] div255(input logic [NUM_W-1:0] x);
        logic [NUM_W:0] t;
        t = {1'b0, x} + (NUM_W+1)'(1) + (NUM_W+1)'(x[NUM_W-1:8]);
        return t[NUM_W-1:8];
    endfunction

    assign status.shade_beat = (s_payload.mode == MODE_SHADE);
    assign m_payload         = out_reg;

    assign full_range = !seen_reg || (depth_low_reg == depth_high_reg);
    assign lo_eff     = full_range ? '0 : depth_low_reg;
    assign hi_eff     = full_range ? DEPTH_BACKGROUND : depth_high_reg;
    assign span_hi    = hi_eff - s_payload.pixel_depth;

    // restoring divide, one quotient bit per step
    assign rem_shift = {rem_reg, num_reg[NUM_W-1]};
    assign q_bit     = (rem_shift >= {1'b0, den_reg});

    assign shade = force_zero_reg ? '0 : (force_full_reg ? FULL_SCALE : num_reg[7:0]);

    assign red_s   = div255(prod_r_reg);
    assign green_s = div255(prod_g_reg);
    assign blue_s  = div255(prod_b_reg);
    // top 5/6/5 bits of each channel
    assign word    = {red_s[7:3], green_s[7:2], blue_s[7:3]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_low_reg  <= DEPTH_BACKGROUND;
            depth_high_reg <= '0;
            seen_reg       <= 1'b0;
        end else if (cmd.scan_update) begin
            if (s_payload.pixel_depth != DEPTH_BACKGROUND) begin
                if (s_payload.pixel_depth < depth_low_reg) begin
                    depth_low_reg <= s_payload.pixel_depth;
                end
                if (s_payload.pixel_depth > depth_high_reg) begin
                    depth_high_reg <= s_payload.pixel_depth;
                end
                seen_reg <= 1'b1;
            end
        end else if (cmd.out_load && last_reg) begin
            depth_low_reg  <= DEPTH_BACKGROUND;
            depth_high_reg <= '0;
            seen_reg       <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_op) begin
            num_reg        <= NUM_W'(span_hi) * NUM_W'(FULL_SCALE);
            den_reg        <= hi_eff - lo_eff;
            rem_reg        <= '0;
            force_zero_reg <= (s_payload.pixel_depth > hi_eff);
            force_full_reg <= (s_payload.pixel_depth < lo_eff);
            red_reg        <= s_payload.red_in;
            green_reg      <= s_payload.green_in;
            blue_reg       <= s_payload.blue_in;
            last_reg       <= s_payload.last_pixel;
        end else if (cmd.div_step) begin
            rem_reg <= q_bit ? DEPTH_W'(rem_shift - {1'b0, den_reg}) : rem_shift[DEPTH_W-1:0];
            num_reg <= {num_reg[NUM_W-2:0], q_bit};
        end
        if (cmd.mul_load) begin
            prod_r_reg <= NUM_W'(red_reg) * NUM_W'(shade);
            prod_g_reg <= NUM_W'(green_reg) * NUM_W'(shade);
            prod_b_reg <= NUM_W'(blue_reg) * NUM_W'(shade);
        end
        if (cmd.out_load) begin
            out_reg.pixel_word   <= word;
            out_reg.end_of_frame <= last_reg;
        end
    end

endmodule

>>> hw/rtl/depth_shade_rgb565_core.sv
// Scan beats (mode 0) are taken one per cycle while the core is idle and give no output.
// Shade beats go through the bit-serial divider, the channel multipliers, then the pack
// into the output register, which waits until the output is free; m_valid follows.
// s_ready returns the cycle after the load; no new beat is taken while a shade beat runs.
// aresetn (synchronous, active low) clears the trackers to min 255, max 0, none seen.
module depth_shade_rgb565_core
    import dsr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_payload,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_payload
);

`include "depth_shade_rgb565_core_macros.svh"

    dsr_cmd_t    cmd;
    dsr_status_t status;

    dsr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    dsr_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cmd       (cmd),
        .status    (status),
        .m_payload (m_payload)
    );

    `DSR_ASSERT_NEXT(a_shade_busy, s_valid && s_ready && s_payload.mode == MODE_SHADE, !s_ready, "shade beat did not hold off input")
    `DSR_ASSERT_NEXT(a_scan_silent, s_valid && s_ready && s_payload.mode == MODE_SCAN && !m_valid, !m_valid, "scan beat produced a word")
    `DSR_ASSERT_SAME(a_no_overwrite, cmd.out_load, !m_valid || m_ready, "output word overwritten")
    `DSR_ASSERT_SAME(a_cmd_onehot, 1'b1, $onehot0(cmd), "conflicting datapath commands")

endmodule

>>> tb/tb_depth_shade_rgb565_core.sv
// Testbench for depth_shade_rgb565_core: directed table plus random frames, checked beat by beat.
`timescale 1ns / 100ps

module tb_depth_shade_rgb565_core;
    import dsr_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1500;
    localparam int unsigned CALM_ITEMS   = 150;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned NUM_ROWS     = 24;

    typedef struct packed {
        in_beat_t  px;
        logic      fixed;
        out_beat_t want;
    } row_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_beat_t  s_payload;
    logic      m_valid;
    logic      m_ready;
    out_beat_t m_payload;

    // tracker copy for prediction
    logic [7:0] depth_low;
    logic [7:0] depth_high;
    logic       any_visible;

    out_beat_t   expected_words[$];
    out_beat_t   head_word;
    int unsigned mismatches;
    int unsigned pixels_sent;
    int unsigned cycles;
    int unsigned send_gap_rate;
    bit          calm;

    // fixed rows carry a hand-computed word; the rest go through the predictor
    row_t directed_rows [NUM_ROWS] = '{
        '{'{MODE_SHADE, 8'hFF, 8'hFF, 8'hFF, 8'd0,   1'b0}, 1'b1, '{16'hFFFF, 1'b0}},
        '{'{MODE_SHADE, 8'hFF, 8'hFF, 8'hFF, 8'd255, 1'b0}, 1'b1, '{16'h0000, 1'b0}},
        '{'{MODE_SHADE, 8'h12, 8'h34, 8'h56, 8'd128, 1'b1}, 1'b0, '0},
        '{'{MODE_SCAN,  8'hFF, 8'hFF, 8'hFF, 8'd255, 1'b0}, 1'b0, '0},
        '{'{MODE_SHADE, 8'hFF, 8'hFF, 8'hFF, 8'd0,   1'b0}, 1'b1, '{16'hFFFF, 1'b0}},
        '{'{MODE_SCAN,  8'h00, 8'h00, 8'h00, 8'd10,  1'b0}, 1'b0, '0},
        '{'{MODE_SCAN,  8'hFF, 8'hFF, 8'hFF, 8'd200, 1'b0}, 1'b0, '0},
        '{'{MODE_SCAN,  8'h5A, 8'hA5, 8'h3C, 8'd255, 1'b0}, 1'b0, '0},
        '{'{MODE_SCAN,  8'h01, 8'h02, 8'h03, 8'd100, 1'b1}, 1'b0, '0},
        '{'{MODE_SHADE, 8'hFF, 8'hFF, 8'hFF, 8'd10,  1'b0}, 1'b1, '{16'hFFFF, 1'b0}},
        '{'{MODE_SHADE, 8'hFF, 8'hFF, 8'hFF, 8'd200, 1'b0}, 1'b1, '{16'h0000, 1'b0}},
        '{'{MODE_SHADE, 8'hFF, 8'hFF, 8'hFF, 8'd5,   1'b0}, 1'b1, '{16'hFFFF, 1'b0}},
        '{'{MODE_SHADE, 8'hFF, 8'hFF, 8'hFF, 8'd250, 1'b0}, 1'b1, '{16'h0000, 1'b0}},
        '{'{MODE_SHADE, 8'hFF, 8'h80, 8'h01, 8'd105, 1'b0}, 1'b0, '0},
        '{'{MODE_SHADE, 8'h00, 8'h00, 8'h00, 8'd100, 1'b0}, 1'b1, '{16'h0000, 1'b0}},
        '{'{MODE_SHADE, 8'hAA, 8'h55, 8'hF0, 8'd255, 1'b1}, 1'b1, '{16'h0000, 1'b1}},
        '{'{MODE_SCAN,  8'h00, 8'h00, 8'h00, 8'd77,  1'b0}, 1'b0, '0},
        '{'{MODE_SCAN,  8'h00, 8'h00, 8'h00, 8'd77,  1'b1}, 1'b0, '0},
        '{'{MODE_SHADE, 8'hFF, 8'hFF, 8'hFF, 8'd77,  1'b0}, 1'b0, '0},
        '{'{MODE_SHADE, 8'hFF, 8'hFF, 8'hFF, 8'd0,   1'b1}, 1'b1, '{16'hFFFF, 1'b1}},
        '{'{MODE_SCAN,  8'h00, 8'h00, 8'h00, 8'd0,   1'b0}, 1'b0, '0},
        '{'{MODE_SCAN,  8'h00, 8'h00, 8'h00, 8'd254, 1'b1}, 1'b0, '0},
        '{'{MODE_SHADE, 8'h80, 8'hC0, 8'hE0, 8'd127, 1'b0}, 1'b0, '0},
        '{'{MODE_SHADE, 8'hFF, 8'hFF, 8'hFF, 8'd254, 1'b1}, 1'b1, '{16'h0000, 1'b1}}
    };

    depth_shade_rgb565_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Scan beats widen the depth range; shade beats produce the packed word and reset the range on the last pixel.
    function automatic out_beat_t shade_and_track(input in_beat_t px);
        int unsigned lo, hi, d, shade, r, g, b;
        out_beat_t   res;
        res = '0;
        d = px.pixel_depth;
        if (px.mode == MODE_SCAN) begin
            if (px.pixel_depth != DEPTH_BACKGROUND) begin
                if (px.pixel_depth < depth_low) depth_low = px.pixel_depth;
                if (px.pixel_depth > depth_high) depth_high = px.pixel_depth;
                any_visible = 1'b1;
            end
            return res;
        end
        lo = depth_low;
        hi = depth_high;
        if (!any_visible || lo == hi) begin
            lo = 0;
            hi = 255;
        end
        if (d > hi) begin
            shade = 0;
        end else if (d < lo) begin
            shade = 255;
        end else if (hi > lo) begin
            shade = ((hi - d) * FULL_SCALE) / (hi - lo);
        end else begin
            shade = 0;
        end
        r = (px.red_in * shade) / FULL_SCALE;
        g = (px.green_in * shade) / FULL_SCALE;
        b = (px.blue_in * shade) / FULL_SCALE;
        res.pixel_word   = 16'(((r & RED_MASK) << 8) | ((g & GREEN_MASK) << 3) | (b >> 3));
        res.end_of_frame = px.last_pixel;
        if (px.last_pixel) begin
            depth_low   = 8'd255;
            depth_high  = 8'd0;
            any_visible = 1'b0;
        end
        return res;
    endfunction

    function automatic logic [7:0] rand_channel();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic in_beat_t rand_pixel(input logic mode, input int unsigned lo,
                                            input int unsigned hi);
        in_beat_t px;
        px.mode        = mode;
        px.red_in      = rand_channel();
        px.green_in    = rand_channel();
        px.blue_in     = rand_channel();
        px.pixel_depth = ($urandom_range(0, 7) == 0) ? DEPTH_BACKGROUND
                                                      : 8'($urandom_range(lo, hi));
        px.last_pixel  = 1'b0;
        return px;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
    endtask

    // Present one beat, wait for the handshake, then log what should come back.
    task automatic send_pixel(input in_beat_t px, input logic fixed, input out_beat_t want);
        out_beat_t   predicted;
        int unsigned gap;
        if (!calm && send_gap_rate != 0 && $urandom_range(0, send_gap_rate) == 0) begin
            gap = $urandom_range(1, 17);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= px;
        do @(posedge aclk); while (!s_ready);
        predicted = shade_and_track(px);
        if (px.mode == MODE_SHADE) expected_words.push_back(fixed ? want : predicted);
        pixels_sent++;
    endtask

    always @(posedge aclk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("unexpected beat word=%h eof=%b",
                                          m_payload.pixel_word, m_payload.end_of_frame));
            end else begin
                head_word = expected_words.pop_front();
                if (m_payload.pixel_word !== head_word.pixel_word)
                    report_mismatch($sformatf("pixel_word exp %h got %h",
                                              head_word.pixel_word, m_payload.pixel_word));
                if (m_payload.end_of_frame !== head_word.end_of_frame)
                    report_mismatch($sformatf("end_of_frame exp %b got %b",
                                              head_word.end_of_frame, m_payload.end_of_frame));
            end
        end
    end

    // Output backpressure: stall rate re-rolled from a tick counter, zero in some phases.
    initial begin : ready_gen
        int unsigned stall_left;
        int unsigned stall_rate;
        int unsigned tick;
        m_ready    = 1'b0;
        stall_left = 0;
        stall_rate = 0;
        tick       = 0;
        forever begin
            @(posedge aclk);
            tick++;
            if (tick % 256 == 0) begin
                case ($urandom_range(0, 2))
                    0:       stall_rate = 0;
                    1:       stall_rate = 3;
                    default: stall_rate = 12;
                endcase
            end
            if (calm || !aresetn) begin
                m_ready <= !calm ? 1'b0 : 1'b1;
            end else if (stall_left != 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (stall_rate != 0 && $urandom_range(0, stall_rate) == 0) begin
                stall_left = $urandom_range(0, 16);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        in_beat_t    frame[$];
        in_beat_t    px;
        int unsigned n, lo_d, hi_d, kind, i;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_payload     = '0;
        depth_low     = 8'd255;
        depth_high    = 8'd0;
        any_visible   = 1'b0;
        mismatches    = 0;
        pixels_sent   = 0;
        cycles        = 0;
        send_gap_rate = 0;
        calm          = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < NUM_ROWS; i++) begin
            send_gap_rate = (i < 12) ? 0 : 3;
            send_pixel(directed_rows[i].px, directed_rows[i].fixed, directed_rows[i].want);
        end

        while (pixels_sent < NUM_ROWS + RANDOM_ITEMS) begin
            calm = (pixels_sent >= NUM_ROWS + RANDOM_ITEMS - CALM_ITEMS);
            case ($urandom_range(0, 2))
                0:       send_gap_rate = 0;
                1:       send_gap_rate = 2;
                default: send_gap_rate = 8;
            endcase
            n    = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            lo_d = $urandom_range(0, 254);
            hi_d = ($urandom_range(0, 5) == 0) ? lo_d : $urandom_range(lo_d, 254);
            kind = $urandom_range(0, 9);
            frame.delete();
            if (kind == 0) begin
                // noise: arbitrary mode and end flags
                repeat (n) begin
                    px = rand_pixel(1'($urandom), 0, 255);
                    px.last_pixel = 1'($urandom);
                    send_pixel(px, 1'b0, '0);
                end
            end else if (kind == 1) begin
                // shade pass with no scan before it
                for (i = 0; i < n; i++) begin
                    px = rand_pixel(MODE_SHADE, 0, 255);
                    px.last_pixel = (i == n - 1);
                    send_pixel(px, 1'b0, '0);
                end
            end else begin
                for (i = 0; i < n; i++) begin
                    px = rand_pixel(MODE_SCAN, lo_d, hi_d);
                    // a broken frame drops the end flag on the scan pass
                    px.last_pixel = (i == n - 1) && (kind != 2);
                    frame.push_back(px);
                    send_pixel(px, 1'b0, '0);
                end
                for (i = 0; i < n; i++) begin
                    px = frame[i];
                    px.mode     = MODE_SHADE;
                    px.red_in   = rand_channel();
                    px.green_in = rand_channel();
                    px.blue_in  = rand_channel();
                    if ($urandom_range(0, 5) == 0) px.pixel_depth = 8'($urandom_range(0, 255));
                    px.last_pixel = (i == n - 1) && (kind != 3);
                    send_pixel(px, 1'b0, '0);
                end
            end
        end
        s_valid <= 1'b0;

        while (expected_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
